// ----- design/sdtc_pkg.sv -----
`timescale 1ns / 1ps
package sdtc_pkg;

  // Sample format and internal unit-fraction format
  localparam int FRAC_BITS = 20;
  localparam int SAMPLE_W  = 28;
  localparam int Q_BITS    = 24;
  localparam int Q_W       = Q_BITS + 1;
  localparam int P24_W     = SAMPLE_W + Q_BITS - FRAC_BITS;

  // Pipeline shape
  localparam int NUM_STAGES = 8;
  localparam int NUM_LANES  = 4;
  localparam int LANE_W     = 2;
  localparam int BYTE_W     = 8;

  // Stage positions in the load-enable vector
  localparam int STG_RAMP  = 0;
  localparam int STG_SQ    = 1;
  localparam int STG_WT    = 2;
  localparam int STG_MIX1P = 3;
  localparam int STG_MIX1  = 4;
  localparam int STG_MIX2P = 5;
  localparam int STG_MIX2  = 6;
  localparam int STG_BYTE  = 7;

  // Palette values in Q24
  localparam logic [Q_W-1:0] Q_ONE = Q_W'(1) << Q_BITS;
  localparam logic [Q_W-1:0] C_02  = Q_W'(3355443);
  localparam logic [Q_W-1:0] C_06  = Q_W'(10066330);
  localparam logic [Q_W-1:0] C_08  = Q_W'(13421773);

  // Color mode codes
  localparam logic MODE_RGB  = 1'b0;
  localparam logic MODE_RGBA = 1'b1;

  // Channel lanes
  localparam logic [LANE_W-1:0] LANE_RED   = 2'd0;
  localparam logic [LANE_W-1:0] LANE_GREEN = 2'd1;
  localparam logic [LANE_W-1:0] LANE_BLUE  = 2'd2;
  localparam logic [LANE_W-1:0] LANE_ALPHA = 2'd3;

  typedef logic [NUM_STAGES-1:0] stage_en_t;
  typedef logic [Q_W-1:0]        qfrac_t;
  typedef logic [BYTE_W-1:0]     byte_t;

  // Color on the inner side of the zero crossing
  function automatic qfrac_t lane_fill(input logic mode, input logic [LANE_W-1:0] lane);
    qfrac_t val;
    val = '0;
    if (mode == MODE_RGBA) begin
      val = (lane == LANE_ALPHA) ? Q_ONE : C_06;
    end else begin
      case (lane)
        LANE_RED:   val = C_02;
        LANE_GREEN: val = C_06;
        LANE_BLUE:  val = C_08;
        default:    val = '0;
      endcase
    end
    return val;
  endfunction

  // Color of the border band around the zero crossing
  function automatic qfrac_t lane_border(input logic mode, input logic [LANE_W-1:0] lane);
    qfrac_t val;
    val = '0;
    if (mode == MODE_RGBA) begin
      val = (lane == LANE_ALPHA) ? Q_ONE : C_02;
    end else begin
      case (lane)
        LANE_RED:   val = C_08;
        LANE_GREEN: val = C_06;
        LANE_BLUE:  val = C_02;
        default:    val = '0;
      endcase
    end
    return val;
  endfunction

  // Base color where it does not come from the gray level
  function automatic qfrac_t lane_base(input logic mode, input logic [LANE_W-1:0] lane);
    qfrac_t val;
    val = '0;
    if (mode == MODE_RGBA && lane != LANE_ALPHA) begin
      val = C_02;
    end
    return val;
  endfunction

endpackage

// ----- design/sdtc_ramp.sv -----
`timescale 1ns / 1ps
module sdtc_ramp (
  input  logic                                   clk,
  input  logic                                   ld,
  input  logic signed [sdtc_pkg::SAMPLE_W-1:0]   sample,
  output sdtc_pkg::qfrac_t                       cross_x_r,
  output sdtc_pkg::qfrac_t                       band_x_r,
  output sdtc_pkg::qfrac_t                       gray_r
);
  import sdtc_pkg::*;

  localparam int LIN_W = P24_W + 10;
  localparam int MAG_W = P24_W + 7;
  localparam logic signed [LIN_W-1:0] HALF_Q = LIN_W'(1) <<< (Q_BITS - 1);

  logic signed [P24_W-1:0] p24;
  logic signed [LIN_W-1:0] p_ext;
  logic signed [LIN_W-1:0] lin;
  logic [P24_W-1:0]        mag;
  logic [MAG_W-1:0]        mag_ext;
  logic [MAG_W-1:0]        band;
  qfrac_t                  cross_x_nxt;
  qfrac_t                  band_x_nxt;
  qfrac_t                  gray_nxt;

  // Align the sample to Q24
  assign p24 = P24_W'(sample) <<< (P24_W - SAMPLE_W);

  // Crossing ramp: p*500 + 0.5, as shift-add
  assign p_ext = LIN_W'(p24);
  assign lin   = (p_ext <<< 9) - (p_ext <<< 3) - (p_ext <<< 2) + HALF_Q;

  // Band ramp: |p|*100, as shift-add
  assign mag     = p24[P24_W-1] ? P24_W'(-p24) : P24_W'(p24);
  assign mag_ext = MAG_W'(mag);
  assign band    = (mag_ext << 6) + (mag_ext << 5) + (mag_ext << 2);

  // Clamp all three to the unit interval
  always_comb begin
    if (lin[LIN_W-1]) begin
      cross_x_nxt = '0;
    end else if (lin > LIN_W'(Q_ONE)) begin
      cross_x_nxt = Q_ONE;
    end else begin
      cross_x_nxt = lin[Q_W-1:0];
    end

    if (band > MAG_W'(Q_ONE)) begin
      band_x_nxt = Q_ONE;
    end else begin
      band_x_nxt = band[Q_W-1:0];
    end

    if (p24[P24_W-1]) begin
      gray_nxt = '0;
    end else if (p24 > P24_W'(Q_ONE)) begin
      gray_nxt = Q_ONE;
    end else begin
      gray_nxt = p24[Q_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      cross_x_r <= cross_x_nxt;
      band_x_r  <= band_x_nxt;
      gray_r    <= gray_nxt;
    end
  end

endmodule

// ----- design/sdtc_smooth.sv -----
`timescale 1ns / 1ps
module sdtc_smooth (
  input  logic                  clk,
  input  sdtc_pkg::stage_en_t   en,
  input  sdtc_pkg::qfrac_t      x,
  output sdtc_pkg::qfrac_t      wt_r
);
  import sdtc_pkg::*;

  localparam int K_W  = Q_W + 1;
  localparam int SQ_W = 2 * Q_W;
  localparam int WT_W = Q_W + K_W;
  localparam logic [K_W-1:0] THREE_Q = K_W'(3) << Q_BITS;

  logic [SQ_W-1:0] sq_full;
  qfrac_t          sq_r, sq_nxt;
  logic [K_W-1:0]  k_r, k_nxt;
  logic [WT_W-1:0] wt_full;
  qfrac_t          wt_nxt;

  // First step: x*x and (3 - 2x)
  assign sq_full = SQ_W'(x) * SQ_W'(x);
  assign sq_nxt  = sq_full[Q_BITS+Q_W-1:Q_BITS];
  assign k_nxt   = THREE_Q - {x, 1'b0};

  // Second step: x*x*(3 - 2x)
  assign wt_full = WT_W'(sq_r) * WT_W'(k_r);
  assign wt_nxt  = wt_full[Q_BITS+Q_W-1:Q_BITS];

  always_ff @(posedge clk) begin
    if (en[STG_SQ]) begin
      sq_r <= sq_nxt;
      k_r  <= k_nxt;
    end
    if (en[STG_WT]) begin
      wt_r <= wt_nxt;
    end
  end

endmodule

// ----- design/sdtc_blend.sv -----
`timescale 1ns / 1ps
module sdtc_blend (
  input  logic                                          clk,
  input  sdtc_pkg::stage_en_t                           en,
  input  logic                                          mode,
  input  sdtc_pkg::qfrac_t                              gray,
  input  sdtc_pkg::qfrac_t                              cross_t,
  input  sdtc_pkg::qfrac_t                              band_t,
  output sdtc_pkg::byte_t [sdtc_pkg::NUM_LANES-1:0]     lane_byte_r
);
  import sdtc_pkg::*;

  localparam int PR_W = 2 * Q_W;
  localparam int SM_W = PR_W + 1;
  localparam int SC_W = Q_W + BYTE_W;
  localparam int HI_W = SC_W - Q_BITS;

  qfrac_t cross_inv;
  qfrac_t band_inv;
  qfrac_t band_d3_r, band_d4_r;
  logic   mode_d3_r, mode_d4_r;

  // Complements of the two weights
  assign cross_inv = Q_ONE - cross_t;
  assign band_inv  = Q_ONE - band_d4_r;

  // Carry the band weight and mode to the second blend
  always_ff @(posedge clk) begin
    if (en[STG_MIX1P]) begin
      band_d3_r <= band_t;
      mode_d3_r <= mode;
    end
    if (en[STG_MIX1]) begin
      band_d4_r <= band_d3_r;
      mode_d4_r <= mode_d3_r;
    end
  end

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    localparam logic [LANE_W-1:0] LANE = LANE_W'(l);

    qfrac_t          base;
    logic [PR_W-1:0] pa_r, pa_nxt, pb_r, pb_nxt;
    logic [SM_W-1:0] sum1;
    qfrac_t          v_r, v_nxt;
    logic [PR_W-1:0] qa_r, qa_nxt, qb_r, qb_nxt;
    logic [SM_W-1:0] sum2;
    qfrac_t          c_r, c_nxt;
    logic [SC_W-1:0] scaled;
    logic [HI_W-1:0] hi;
    byte_t           byte_nxt;

    // Pick the start color: gray level for color lanes in rgb mode
    assign base = (mode == MODE_RGB && LANE != LANE_ALPHA) ? gray : lane_base(mode, LANE);

    // First blend toward fill by the crossing weight
    assign pa_nxt = PR_W'(lane_fill(mode, LANE)) * PR_W'(cross_inv);
    assign pb_nxt = PR_W'(base) * PR_W'(cross_t);
    assign sum1   = SM_W'(pa_r) + SM_W'(pb_r);
    assign v_nxt  = sum1[Q_BITS+Q_W-1:Q_BITS];

    // Second blend toward border by the band weight
    assign qa_nxt = PR_W'(lane_border(mode_d4_r, LANE)) * PR_W'(band_inv);
    assign qb_nxt = PR_W'(v_r) * PR_W'(band_d4_r);
    assign sum2   = SM_W'(qa_r) + SM_W'(qb_r);
    assign c_nxt  = sum2[Q_BITS+Q_W-1:Q_BITS];

    // Scale by 255, truncate and saturate
    assign scaled   = {c_r, {BYTE_W{1'b0}}} - SC_W'(c_r);
    assign hi       = scaled[SC_W-1:Q_BITS];
    assign byte_nxt = (hi > HI_W'(255)) ? 8'hFF : hi[BYTE_W-1:0];

    always_ff @(posedge clk) begin
      if (en[STG_MIX1P]) begin
        pa_r <= pa_nxt;
        pb_r <= pb_nxt;
      end
      if (en[STG_MIX1]) begin
        v_r <= v_nxt;
      end
      if (en[STG_MIX2P]) begin
        qa_r <= qa_nxt;
        qb_r <= qb_nxt;
      end
      if (en[STG_MIX2]) begin
        c_r <= c_nxt;
      end
      if (en[STG_BYTE]) begin
        lane_byte_r[l] <= byte_nxt;
      end
    end
  end

endmodule

// ----- design/sdf_to_color_map.sv -----
`timescale 1ns / 1ps
// Signed distance to color pixel map.
// Input beats carry one 28-bit signed distance sample (20 fraction bits) on
// in_distance_sample with in_valid/in_ready. Output beats carry one pixel as
// out_red, out_green, out_blue and out_alpha with out_valid/out_ready.
// cfg_wr_en writes cfg_color_mode: 0 gives the rgb palette with alpha zero,
// 1 gives the rgba gray palette. Write it only while no beat is in flight.
// Each input beat passes through eight register stages to the output, and one
// beat per cycle is sustained while the receiver takes beats. The stages are
// ramp and clamp, the two multiply steps of the smoothstep, product and sum of
// each of the two blends, and the byte scaling.
// Each stage holds its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles close up and in_ready stays high while
// any stage is empty. When the receiver stalls, up to eight beats are held
// and in_ready drops only once every stage is full.
// Reset (rst_n low, synchronous) empties the pipeline and sets color_mode
// back to rgb.
module sdf_to_color_map (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [sdtc_pkg::SAMPLE_W-1:0]  in_distance_sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [sdtc_pkg::BYTE_W-1:0]           out_red,
  output logic [sdtc_pkg::BYTE_W-1:0]           out_green,
  output logic [sdtc_pkg::BYTE_W-1:0]           out_blue,
  output logic [sdtc_pkg::BYTE_W-1:0]           out_alpha,
  input  logic                                  cfg_wr_en,
  input  logic                                  cfg_color_mode
);
  import sdtc_pkg::*;

  logic      color_mode_r, color_mode_nxt;
  stage_en_t vld_r, vld_nxt;
  stage_en_t adv;
  qfrac_t    cross_x, band_x, gray0;
  qfrac_t    gray_d1_r, gray_d2_r;
  logic      mode_d0_r, mode_d1_r, mode_d2_r;
  qfrac_t    cross_t, band_t;
  byte_t [NUM_LANES-1:0] lane_byte;

  // Mode register
  assign color_mode_nxt = cfg_wr_en ? cfg_color_mode : color_mode_r;

  // Stage advance: a stage moves when empty or when the next one moves
  always_comb begin
    adv[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || out_ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  always_comb begin
    vld_nxt[0] = adv[0] ? in_valid : vld_r[0];
    for (int i = 1; i < NUM_STAGES; i++) begin
      vld_nxt[i] = adv[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_mode_r <= MODE_RGB;
      vld_r        <= '0;
    end else begin
      color_mode_r <= color_mode_nxt;
      vld_r        <= vld_nxt;
    end
  end

  // Carry gray level and mode alongside the smoothstep stages
  always_ff @(posedge clk) begin
    if (adv[STG_RAMP]) begin
      mode_d0_r <= color_mode_r;
    end
    if (adv[STG_SQ]) begin
      gray_d1_r <= gray0;
      mode_d1_r <= mode_d0_r;
    end
    if (adv[STG_WT]) begin
      gray_d2_r <= gray_d1_r;
      mode_d2_r <= mode_d1_r;
    end
  end

  sdtc_ramp u_ramp (
    .clk       (clk),
    .ld        (adv[STG_RAMP]),
    .sample    (in_distance_sample),
    .cross_x_r (cross_x),
    .band_x_r  (band_x),
    .gray_r    (gray0)
  );

  sdtc_smooth u_smooth_cross (
    .clk  (clk),
    .en   (adv),
    .x    (cross_x),
    .wt_r (cross_t)
  );

  sdtc_smooth u_smooth_band (
    .clk  (clk),
    .en   (adv),
    .x    (band_x),
    .wt_r (band_t)
  );

  sdtc_blend u_blend (
    .clk         (clk),
    .en          (adv),
    .mode        (mode_d2_r),
    .gray        (gray_d2_r),
    .cross_t     (cross_t),
    .band_t      (band_t),
    .lane_byte_r (lane_byte)
  );

  assign in_ready  = adv[STG_RAMP];
  assign out_valid = vld_r[NUM_STAGES-1];
  assign out_red   = lane_byte[LANE_RED];
  assign out_green = lane_byte[LANE_GREEN];
  assign out_blue  = lane_byte[LANE_BLUE];
  assign out_alpha = lane_byte[LANE_ALPHA];

  // A receiver that takes beats never throttles intake
  assert property (@(posedge clk) disable iff (!rst_n) out_ready |-> in_ready)
    else $error("intake blocked while output is drained");

  // Intake stops only with every stage full and the output stalled
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> ((&vld_r) && !out_ready))
    else $error("intake blocked with room in the pipeline");

  // A held first stage keeps its beat
  assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[STG_RAMP] && !adv[STG_RAMP]) |=> vld_r[STG_RAMP])
    else $error("held beat lost in first stage");

endmodule
